@@ rtl/core/dplp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dplp_pkg
// Types and constants shared by the debounced power-level PWM core.
// ----------------------------------------------------------------------------
package dplp_pkg;

    // Width of one PWM threshold and of the PWM counter.
    localparam int unsigned PWM_W = 8;

    // Threshold values after reset, one for each power level.
    localparam logic [PWM_W-1:0] LEVEL0_RESET = 8'd0;
    localparam logic [PWM_W-1:0] LEVEL1_RESET = 8'd200;
    localparam logic [PWM_W-1:0] LEVEL2_RESET = 8'd224;
    localparam logic [PWM_W-1:0] LEVEL3_RESET = 8'd255;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LEVEL0 = 2'd0;
    localparam logic [1:0] REG_LEVEL1 = 2'd1;
    localparam logic [1:0] REG_LEVEL2 = 2'd2;
    localparam logic [1:0] REG_LEVEL3 = 2'd3;

    // Tick kinds.
    localparam logic MODE_PWM      = 1'b0;
    localparam logic MODE_DEBOUNCE = 1'b1;

    // One input beat.
    typedef struct packed {
        logic mode;
        logic key_level;
    } dplp_tick_t;

    // One result beat.
    typedef struct packed {
        logic       drive_on;
        logic [1:0] level_index;
        logic       button_held;
        logic       press_event;
    } dplp_result_t;

    // Debouncer status for the tick being accepted.
    typedef struct packed {
        logic held;
        logic press;
    } dplp_deb_status_t;

endpackage : dplp_pkg
`default_nettype wire

@@ rtl/core/debounced_power_level_pwm_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_power_level_pwm_core
// Heater PWM with four programmable power levels, stepped by a debounced
// push button.
// ----------------------------------------------------------------------------
// The result beat of an accepted tick is registered and offered in the next cycle.
// Throughput: one tick per cycle; the single output register is refilled in
// the same cycle that its beat is taken, so the input stalls only while a
// result waits under a downstream stall.
// Reset: rst_n clears the PWM counter, drive, level and debounced state,
// loads the vertical counter with ones and the thresholds with their defaults.
module debounced_power_level_pwm_core
    import dplp_pkg::*;
#(
    parameter int unsigned LEVELS = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    // Tick channel.
    input  wire logic          tick_valid,
    output logic               tick_stall,
    input  wire dplp_tick_t    tick,

    // Result channel.
    output logic               result_valid,
    input  wire logic          result_stall,
    output dplp_result_t       result,

    // Configuration port.
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // The highest level index in use; the level wraps to zero after it.
    localparam logic [1:0] LAST_LEVEL = 2'(LEVELS - 1);

    // ------------------------------------------------------------------
    // Configuration registers. Each threshold is its own register so that
    // the PWM compare and the bus read select among them independently.
    // ------------------------------------------------------------------
    logic [PWM_W-1:0] thr0_reg;
    logic [PWM_W-1:0] thr1_reg;
    logic [PWM_W-1:0] thr2_reg;
    logic [PWM_W-1:0] thr3_reg;
    logic             cfg_write;
    logic [1:0]       cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr0_reg <= LEVEL0_RESET;
            thr1_reg <= LEVEL1_RESET;
            thr2_reg <= LEVEL2_RESET;
            thr3_reg <= LEVEL3_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LEVEL0: thr0_reg <= pwdata[PWM_W-1:0];
                REG_LEVEL1: thr1_reg <= pwdata[PWM_W-1:0];
                REG_LEVEL2: thr2_reg <= pwdata[PWM_W-1:0];
                REG_LEVEL3: thr3_reg <= pwdata[PWM_W-1:0];
                default:    thr0_reg <= thr0_reg;
            endcase
        end
    end

    // Reads return the addressed threshold, zero-extended to the bus width.
    always_comb
    begin
        unique case (cfg_index)
            REG_LEVEL0: prdata = {{(32-PWM_W){1'b0}}, thr0_reg};
            REG_LEVEL1: prdata = {{(32-PWM_W){1'b0}}, thr1_reg};
            REG_LEVEL2: prdata = {{(32-PWM_W){1'b0}}, thr2_reg};
            REG_LEVEL3: prdata = {{(32-PWM_W){1'b0}}, thr3_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. A tick is taken whenever the output register is empty or
    // its beat leaves in the same cycle.
    // ------------------------------------------------------------------
    logic tick_accept;

    assign tick_stall  = result_valid & result_stall;
    assign tick_accept = tick_valid & ~tick_stall;

    // ------------------------------------------------------------------
    // PWM state. On a PWM tick the drive turns on at count zero and off
    // when the count meets the selected threshold; the off test wins, so
    // a threshold of zero keeps the drive off.
    // ------------------------------------------------------------------
    logic [PWM_W-1:0] count_reg;
    logic [PWM_W-1:0] count_next;
    logic             drive_reg;
    logic             drive_next;
    logic [1:0]       level_reg;
    logic [1:0]       level_next;
    logic [PWM_W-1:0] threshold;
    logic             pwm_tick;
    logic             deb_tick;

    assign pwm_tick = tick_accept & (tick.mode == MODE_PWM);
    assign deb_tick = tick_accept & (tick.mode == MODE_DEBOUNCE);

    always_comb
    begin
        unique case (level_reg)
            REG_LEVEL0: threshold = thr0_reg;
            REG_LEVEL1: threshold = thr1_reg;
            REG_LEVEL2: threshold = thr2_reg;
            REG_LEVEL3: threshold = thr3_reg;
            default:    threshold = thr0_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg + PWM_W'(1);
        priority if (count_reg == threshold)
            drive_next = 1'b0;
        else if (count_reg == '0)
            drive_next = 1'b1;
        else
            drive_next = drive_reg;
    end

    // ------------------------------------------------------------------
    // Button debouncer. A new debounced press steps the level at once.
    // ------------------------------------------------------------------
    dplp_deb_status_t deb_status;

    dplp_debounce u_debounce (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (deb_tick),
        .key_level  (tick.key_level),
        .status     (deb_status)
    );

    assign level_next = (level_reg == LAST_LEVEL) ? 2'd0 : level_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drive_reg <= 1'b0;
            level_reg <= 2'd0;
        end
        else
        begin
            if (pwm_tick)
            begin
                count_reg <= count_next;
                drive_reg <= drive_next;
            end
            if (deb_tick && deb_status.press)
            begin
                level_reg <= level_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register. It carries the state as it stands after the tick;
    // a PWM tick never reports a press and leaves the debounced state as
    // it was.
    // ------------------------------------------------------------------
    dplp_result_t result_reg;
    dplp_result_t result_next;
    logic         result_valid_reg;
    logic         result_valid_next;

    always_comb
    begin
        if (tick.mode == MODE_PWM)
        begin
            result_next.drive_on    = drive_next;
            result_next.level_index = level_reg;
            result_next.button_held = deb_status.held;
            result_next.press_event = 1'b0;
        end
        else
        begin
            result_next.drive_on    = drive_reg;
            result_next.level_index = deb_status.press ? level_next : level_reg;
            result_next.button_held = deb_status.held;
            result_next.press_event = deb_status.press;
        end
    end

    assign result_valid_next = tick_accept | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule : debounced_power_level_pwm_core
`default_nettype wire

@@ rtl/core/dplp_debounce.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dplp_debounce
// Two-bit vertical counter debouncer for the active-low button.
// ----------------------------------------------------------------------------
module dplp_debounce
    import dplp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample,
    input  wire logic             key_level,
    output dplp_deb_status_t      status
);

    logic vc_low_reg;
    logic vc_low_next;
    logic vc_high_reg;
    logic vc_high_next;
    logic held_reg;
    logic held_next;
    logic changed;
    logic toggle;

    // The counter runs while the sample disagrees with the debounced state
    // and is reloaded as soon as the two agree; the fourth disagreement
    // toggles the state. Without a sample the status shows the stored state.
    always_comb
    begin
        changed      = held_reg ^ ~key_level;
        vc_low_next  = ~(vc_low_reg & changed);
        vc_high_next = vc_low_next ^ (vc_high_reg & changed);
        toggle       = changed & vc_low_next & vc_high_next;
        held_next    = held_reg ^ toggle;
        status.held  = sample ? held_next : held_reg;
        status.press = sample & held_next & toggle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_low_reg  <= 1'b1;
            vc_high_reg <= 1'b1;
            held_reg    <= 1'b0;
        end
        else if (sample)
        begin
            vc_low_reg  <= vc_low_next;
            vc_high_reg <= vc_high_next;
            held_reg    <= held_next;
        end
    end

endmodule : dplp_debounce
`default_nettype wire

@@ tb/sv/debounced_power_level_pwm_core_tb.sv @@
// ----------------------------------------------------------------------------
// debounced_power_level_pwm_core_tb
// Self-checking bench for the heater PWM core with debounced level stepping.
// A queue of tick beats feeds a clocked driver. A clocked monitor checks every
// result beat against a behavioural copy of the counter, drive, vertical
// counter debouncer and level selector. Thresholds are reprogrammed over the
// APB port between phases, and both channels idle in random bursts.
// ----------------------------------------------------------------------------
module debounced_power_level_pwm_core_tb;
    import dplp_pkg::*;

    localparam int          LEVEL_COUNT  = 4;
    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 6;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          REPORT_MAX   = 10;
    // The button is active low behind a pull-up.
    localparam logic        PIN_PRESSED  = 1'b0;
    localparam logic        PIN_RELEASED = 1'b1;

    // Clock, reset and every block input start at a known value.
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               tick_valid   = 1'b0;
    dplp_tick_t         tick_beat    = '0;
    logic               result_stall = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [3:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;

    logic               tick_stall;
    logic               result_valid;
    dplp_result_t       result_beat;
    logic [31:0]        prdata;
    logic               pready;

    // Behavioural copy of the core's state and thresholds.
    logic [PWM_W-1:0]   level_thr [4];
    logic [PWM_W-1:0]   heat_count;
    logic               heat_drive;
    logic               vc_lo;
    logic               vc_hi;
    logic               btn_state;
    logic [1:0]         level_sel;

    dplp_tick_t         tick_queue[$];
    dplp_result_t       expected_results[$];

    int                 mismatches   = 0;
    int                 cycle_count  = 0;
    // Idling is switched off for the closing phase.
    logic               allow_idle   = 1'b1;
    // Set once by the stimulus; the monitor then holds off for a long stretch.
    logic               hold_armed   = 1'b0;
    logic               hold_done    = 1'b0;
    int                 hold_left    = 0;
    int                 tx_gap       = 0;
    int                 rx_gap       = 0;

    debounced_power_level_pwm_core #(
        .LEVELS       (LEVEL_COUNT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Predicts the result beat of one tick and advances the copied state.
    // On a PWM tick the on test comes first, so a zero threshold switches the
    // drive straight back off. On a debounce tick the two-bit vertical counter
    // must see four samples that disagree with the debounced state in a row.
    function automatic dplp_result_t heater_next(dplp_tick_t t);
        dplp_result_t r;
        logic         changed;
        logic         press;
        int           next_level;
        press = 1'b0;
        if (t.mode == MODE_PWM)
        begin
            if (heat_count == '0)
                heat_drive = 1'b1;
            if (heat_count == level_thr[level_sel])
                heat_drive = 1'b0;
            heat_count = heat_count + 1'b1;
        end
        else
        begin
            changed   = btn_state ^ ~t.key_level;
            vc_lo     = ~(vc_lo & changed);
            vc_hi     = vc_lo ^ (vc_hi & changed);
            changed   = changed & vc_lo & vc_hi;
            btn_state = btn_state ^ changed;
            press     = btn_state & changed;
            if (press)
            begin
                next_level = int'(level_sel) + 1;
                if (next_level >= LEVEL_COUNT)
                    next_level = 0;
                level_sel = next_level[1:0];
            end
        end
        r.drive_on    = heat_drive;
        r.level_index = level_sel;
        r.button_held = btn_state;
        r.press_event = press;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // Driver: predicts each accepted beat, then offers the next one unless a
    // gap burst is running. A stalled beat is held unchanged.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            tx_gap     <= 0;
        end
        else if (!(tick_valid && tick_stall))
        begin
            if (tick_valid)
                expected_results.push_back(heater_next(tick_beat));
            if (tx_gap > 0)
            begin
                tick_valid <= 1'b0;
                tx_gap     <= tx_gap - 1;
            end
            else if (allow_idle && $urandom_range(0, 9) == 0)
            begin
                tick_valid <= 1'b0;
                tx_gap     <= $urandom_range(1, 18) - 1;
            end
            else if (tick_queue.size() != 0)
            begin
                tick_beat  <= tick_queue.pop_front();
                tick_valid <= 1'b1;
            end
            else
            begin
                tick_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result beat against the oldest prediction,
    // then decides the stall for the next cycle. The long hold-off is counted
    // here so that the sender keeps offering beats and the core backs up.
    always @(posedge clk or negedge rst_n)
    begin
        dplp_result_t want;
        int           gap_next;
        int           hold_next;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_gap       <= 0;
            hold_left    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    note_mismatch("unexpected result beat", 0, 1);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_beat.drive_on !== want.drive_on)
                        note_mismatch("drive_on", want.drive_on, result_beat.drive_on);
                    if (result_beat.level_index !== want.level_index)
                        note_mismatch("level_index", want.level_index,
                                      result_beat.level_index);
                    if (result_beat.button_held !== want.button_held)
                        note_mismatch("button_held", want.button_held,
                                      result_beat.button_held);
                    if (result_beat.press_event !== want.press_event)
                        note_mismatch("press_event", want.press_event,
                                      result_beat.press_event);
                end
            end
            gap_next  = rx_gap;
            hold_next = hold_left;
            if (hold_armed && !hold_done)
            begin
                hold_next = HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_next > 0)
            begin
                hold_next--;
            end
            if (gap_next > 0)
                gap_next--;
            else if (allow_idle && $urandom_range(0, 9) == 0)
                gap_next = $urandom_range(1, 18);
            rx_gap       <= gap_next;
            hold_left    <= hold_next;
            result_stall <= (gap_next > 0) || (hold_next > 0);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // One APB transfer: setup cycle, then access until pready is seen.
    task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata   = prdata;
        if (wr)
            level_thr[idx] = wdata[PWM_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads every threshold back and compares it with the copied value.
    task automatic check_levels();
        logic [31:0] rd;
        for (int i = 0; i < 4; i++)
        begin
            apb_transfer(1'b0, i[1:0], '0, rd);
            if (rd[PWM_W-1:0] !== level_thr[i])
                note_mismatch($sformatf("threshold readback %0d", i),
                              level_thr[i], rd[PWM_W-1:0]);
        end
    endtask

    // Programs all four thresholds; the bits above the threshold width are
    // filled with noise, which the core must drop.
    task automatic program_levels(input logic [PWM_W-1:0] t0, input logic [PWM_W-1:0] t1,
                                  input logic [PWM_W-1:0] t2, input logic [PWM_W-1:0] t3);
        logic [31:0]      rd;
        logic [31:0]      wd;
        logic [PWM_W-1:0] vals [4];
        logic [1:0]       regs [4];
        vals = '{t0, t1, t2, t3};
        regs = '{REG_LEVEL0, REG_LEVEL1, REG_LEVEL2, REG_LEVEL3};
        for (int i = 0; i < 4; i++)
        begin
            wd             = $urandom();
            wd[PWM_W-1:0]  = vals[i];
            apb_transfer(1'b1, regs[i], wd, rd);
        end
        check_levels();
    endtask

    task automatic add_tick(input logic mode, input logic pin);
        dplp_tick_t t;
        t.mode      = mode;
        t.key_level = pin;
        tick_queue.push_back(t);
    endtask

    // Mostly clean press and release runs of four to seven samples with PWM
    // ticks between them, so that levels keep stepping and the counter wraps;
    // the rest is short bursts of arbitrary ticks that bounce the debouncer.
    task automatic add_random_ticks(input int count);
        int   added;
        int   run;
        logic pin_level;
        added     = 0;
        pin_level = PIN_PRESSED;
        while (added < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                run = $urandom_range(4, 7);
                for (int k = 0; k < run; k++)
                    add_tick(MODE_DEBOUNCE, pin_level);
                pin_level = ~pin_level;
                added += run;
                run = $urandom_range(1, 30);
                for (int k = 0; k < run; k++)
                    add_tick(MODE_PWM, 1'($urandom_range(0, 1)));
                added += run;
            end
            else
            begin
                run = $urandom_range(1, 6);
                for (int k = 0; k < run; k++)
                    add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                added += run;
            end
        end
    endtask

    // Waits until every beat has been sent and every result has come back,
    // then lets the core settle.
    task automatic wait_drained();
        while (tick_queue.size() != 0 || tick_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        level_thr  = '{LEVEL0_RESET, LEVEL1_RESET, LEVEL2_RESET, LEVEL3_RESET};
        heat_count = '0;
        heat_drive = 1'b0;
        vc_lo      = 1'b1;
        vc_hi      = 1'b1;
        btn_state  = 1'b0;
        level_sel  = 2'd0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // The thresholds must come out of reset at their defaults.
        check_levels();

        // Directed part at the reset thresholds. Level zero has threshold
        // zero, so the first PWM ticks, count zero among them, leave the
        // drive off.
        add_tick(MODE_PWM, PIN_PRESSED);
        add_tick(MODE_PWM, PIN_RELEASED);
        add_tick(MODE_PWM, PIN_PRESSED);
        // Four pressed samples give a debounced press and step to level one.
        repeat (4) add_tick(MODE_DEBOUNCE, PIN_PRESSED);
        // Four released samples give a release with no event.
        repeat (4) add_tick(MODE_DEBOUNCE, PIN_RELEASED);
        // A bounce: the released sample restarts the vertical counter.
        repeat (2) add_tick(MODE_DEBOUNCE, PIN_PRESSED);
        add_tick(MODE_DEBOUNCE, PIN_RELEASED);
        repeat (4) add_tick(MODE_DEBOUNCE, PIN_PRESSED);
        // Level two now; PWM ticks with the button held down.
        repeat (3) add_tick(MODE_PWM, PIN_RELEASED);
        repeat (4) add_tick(MODE_DEBOUNCE, PIN_RELEASED);
        wait_drained();

        add_random_ticks(140);
        wait_drained();

        // Extremes on different levels; the receiver holds off for a long
        // stretch early in this phase so that the core fills and stalls.
        program_levels(8'd0, 8'd255, 8'd1, 8'd254);
        add_random_ticks(140);
        hold_armed <= 1'b1;
        wait_drained();

        // Threshold 255 everywhere: the drive drops for the one tick at 255.
        program_levels(8'd255, 8'd255, 8'd255, 8'd255);
        add_random_ticks(140);
        wait_drained();

        // Threshold zero everywhere: zero duty on every level.
        program_levels(8'd0, 8'd0, 8'd0, 8'd0);
        add_random_ticks(100);
        wait_drained();

        // Closing phase at random thresholds with both sides running flat out.
        program_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        allow_idle <= 1'b0;
        add_random_ticks(200);
        wait_drained();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
